// File: hdl/unsigned_to_decimal_text_assert.svh
// assertion macros shared by the decimal text converter
// expects clk and arst_n in the scope where a macro is used
`ifndef UNSIGNED_TO_DECIMAL_TEXT_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_TEXT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define UDT_ASSERT_ON(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies the consequence in the next cycle
`define UDT_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/udt_pkg.sv
// types and constants of the decimal text converter
// no dependencies
`default_nettype none

package udt_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 6;
	localparam int CNT_W = 4;
	// a 32-bit value never has more decimal digits than this
	localparam int MAX_DEC_DIGITS = 10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	// ceil(2^35 / 10): exact quotient by ten for every 32-bit value
	localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	// one converted number waiting in the store
	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] cnt;
	} job_t;

	// job queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hdl/udt_value_if.sv
// input channel of the converter: one unsigned value per item
// depends on udt_pkg
`default_nettype none

interface udt_value_if import udt_pkg::*; ();

	logic valid;
	logic ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/udt_char_if.sv
// output channel of the converter: one digit character per item
// depends on udt_pkg
`default_nettype none

interface udt_char_if import udt_pkg::*; ();

	logic valid;
	logic ready;
	logic [CHAR_W-1:0] digit_char;
	logic last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/udt_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module udt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 20
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/udt_front.sv
// front end: accepts a value and splits it into decimal digits, one a cycle
// depends on udt_pkg, udt_value_if and the assertion macros
`default_nettype none
`include "unsigned_to_decimal_text_assert.svh"

module udt_front import udt_pkg::*; #(
	parameter int MAX_DIGITS = 10,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	udt_value_if.sink number,
	input wire q_stat_t qstat,
	output logic push,
	output job_t job,
	output logic we,
	output logic [AW-1:0] waddr,
	output logic [DIGIT_W-1:0] wdata
);

	localparam int LIMIT = (MAX_DIGITS < MAX_DEC_DIGITS) ? MAX_DIGITS : MAX_DEC_DIGITS;
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

	logic busy_q;
	logic bank_q;
	logic [VALUE_W-1:0] v_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] rem_full;
	logic [CNT_W-1:0] cnt_nxt;

	// a new value only when the other store bank is free
	assign number.ready = !busy_q && !qstat.full;

	// divide by ten through the reciprocal, remainder by subtraction
	assign prod = {{VALUE_W{1'b0}}, v_q} * {{VALUE_W{1'b0}}, RECIP_10};
	assign quot = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
	assign rem_full = v_q - ((quot << 3) + (quot << 1));

	// digit write, dropped once the store is full
	assign we = busy_q && (cnt_q < LIMIT_C);
	assign wdata = rem_full[DIGIT_W-1:0];
	assign waddr = bank_q ? (AW'(MAX_DIGITS) + AW'(cnt_q)) : AW'(cnt_q);
	assign cnt_nxt = we ? (cnt_q + CNT_W'(1)) : cnt_q;

	// hand the finished number to the queue
	assign push = busy_q && (quot == '0);
	assign job = '{bank: bank_q, cnt: cnt_nxt};

	// conversion control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (number.valid && number.ready) begin
			busy_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
			bank_q <= ~bank_q;
		end
	end

	// working value and digit count
	always_ff @(posedge clk) begin
		if (number.valid && number.ready) begin
			v_q <= number.value;
			cnt_q <= '0;
		end else if (busy_q) begin
			v_q <= quot;
			cnt_q <= cnt_nxt;
		end
	end

	`UDT_ASSERT_ON(a_push_room, !push || !qstat.full, "job pushed into a full queue")
	`UDT_ASSERT_ON(a_push_count, !push || (job.cnt != '0), "job pushed with no digits")

endmodule

`default_nettype wire

// File: hdl/udt_job_queue.sv
// two-entry queue of converted numbers between front and back end
// depends on udt_pkg
`default_nettype none

module udt_job_queue import udt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire job_t job_in,
	input wire logic pop,
	output job_t head,
	output q_stat_t qstat
);

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	assign head = mem_q[rd_ptr_q];
	assign qstat.full = (fill_q == 2'd2);
	assign qstat.empty = (fill_q == 2'd0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

`default_nettype wire

// File: hdl/udt_back.sv
// back end: reads the digits of one number high end first and sends characters
// depends on udt_pkg, udt_char_if and the assertion macros
`default_nettype none
`include "unsigned_to_decimal_text_assert.svh"

module udt_back import udt_pkg::*; #(
	parameter int MAX_DIGITS = 10,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	udt_char_if.source text,
	input wire job_t head,
	input wire q_stat_t qstat,
	output logic pop,
	output logic re,
	output logic [AW-1:0] raddr,
	input wire logic [DIGIT_W-1:0] rdata
);

	logic active_q;
	logic [CNT_W-1:0] rem_q;
	logic pend_s1;
	logic last_s1;
	logic out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic last_q;
	logic [CNT_W-1:0] idx;
	logic is_last;
	logic move;

	// read data moves on when the output register is free or being taken
	assign move = pend_s1 && (!out_valid_q || text.ready);
	assign idx = rem_q - CNT_W'(1);
	assign is_last = (rem_q == CNT_W'(1));
	assign re = active_q && (!pend_s1 || move);
	assign raddr = head.bank ? (AW'(MAX_DIGITS) + AW'(idx)) : AW'(idx);
	// the bank is released once its lowest digit is read
	assign pop = re && is_last;

	assign text.valid = out_valid_q;
	assign text.digit_char = char_q;
	assign text.last = last_q;

	// read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (!active_q && !qstat.empty) begin
				active_q <= 1'b1;
			end else if (pop) begin
				active_q <= 1'b0;
			end
			if (re) begin
				pend_s1 <= 1'b1;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// digit countdown and last flag beside the read data
	always_ff @(posedge clk) begin
		if (!active_q && !qstat.empty) begin
			rem_q <= head.cnt;
		end else if (re) begin
			rem_q <= idx;
		end
		if (re) begin
			last_s1 <= is_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			char_q <= ASCII_ZERO + CHAR_W'(rdata);
			last_q <= last_s1;
		end
	end

	`UDT_ASSERT_ON(a_pop_nonempty, !pop || !qstat.empty, "pop from an empty queue")
	`UDT_ASSERT_ON(a_digit_range, !pend_s1 || (rdata <= DIGIT_MAX), "stored digit above nine")
	`UDT_ASSERT_NEXT(a_read_lands, re, pend_s1, "issued read not held for output")

endmodule

`default_nettype wire

// File: hdl/unsigned_to_decimal_text.sv
// flow: a value's n digits are divided out one a cycle into the digit store; the back
//   end reaches the first character through its read sequencing, registered store read
//   and output register, then sends one character a cycle while the sink takes them;
//   a new value is taken once the previous one is divided and a store bank is free
// reset: arst_n clears all control state at once; the digit store is not cleared
// and each entry is written before it is read
`default_nettype none

module unsigned_to_decimal_text import udt_pkg::*; #(
	parameter int MAX_DIGITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	udt_value_if.sink number,
	udt_char_if.source text
);

	// two store banks, one filled by the front while the back drains the other
	localparam int DEPTH = 2 * MAX_DIGITS;
	localparam int AW = $clog2(DEPTH);

	logic push;
	logic pop;
	job_t job;
	job_t head;
	q_stat_t qstat;
	logic we;
	logic re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [DIGIT_W-1:0] wdata;
	logic [DIGIT_W-1:0] rdata;

	udt_front #(.MAX_DIGITS(MAX_DIGITS), .AW(AW)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.number(number),
		.qstat(qstat),
		.push(push),
		.job(job),
		.we(we),
		.waddr(waddr),
		.wdata(wdata)
	);

	udt_job_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.job_in(job),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	udt_ram #(.WIDTH(DIGIT_W), .DEPTH(DEPTH)) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	udt_back #(.MAX_DIGITS(MAX_DIGITS), .AW(AW)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

`default_nettype wire

// File: dv/tb_unsigned_to_decimal_text.sv
// self-checking testbench of the decimal text converter: a directed table, then random values
// depends on udt_pkg, udt_value_if, udt_char_if and unsigned_to_decimal_text
`default_nettype none

module tb_unsigned_to_decimal_text import udt_pkg::*; ();

	localparam int DIGITS_DEPTH = 10;
	localparam int RANDOM_VALUES = 210;
	localparam int DRAIN_AT = 100;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [VALUE_W-1:0] RADIX = 32'd10;

	typedef logic [CHAR_W-1:0] char_t;

	// one expected digit character
	typedef struct {
		char_t digit_char;
		logic last;
	} char_item_t;

	// a directed value; text left empty means the predictor decides
	typedef struct {
		logic [VALUE_W-1:0] value;
		string text;
	} value_row_t;

	localparam int N_ROWS = 22;
	value_row_t value_rows [N_ROWS] = '{
		'{32'd0, "0"},
		'{32'd1, "1"},
		'{32'd9, "9"},
		'{32'd10, "10"},
		'{32'd99, ""},
		'{32'd100, ""},
		'{32'd101, ""},
		'{32'd999, ""},
		'{32'd1000, ""},
		'{32'd65535, ""},
		'{32'd99999, ""},
		'{32'd1000000, ""},
		'{32'd9999999, ""},
		'{32'd999999999, ""},
		'{32'd1000000000, "1000000000"},
		'{32'h7FFF_FFFF, ""},
		'{32'h8000_0000, "2147483648"},
		'{32'hAAAA_AAAA, ""},
		'{32'h5555_5555, ""},
		'{32'hFFFF_0000, ""},
		'{32'hFFFF_FFFE, ""},
		'{32'hFFFF_FFFF, "4294967295"}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	udt_value_if number_ch();
	udt_char_if text_ch();

	unsigned_to_decimal_text #(
		.MAX_DIGITS(DIGITS_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.number(number_ch),
		.text(text_ch)
	);

	char_item_t expected_chars [$];
	int errors = 0;
	int chars_seen = 0;
	int text_hold = 0;
	bit text_stalls = 1'b1;
	bit number_gaps = 1'b1;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// decimal digits of a number, most significant first, into the expected queue
	function automatic void predict_text(input logic [VALUE_W-1:0] num);
		logic [DIGIT_W-1:0] digits [DIGITS_DEPTH];
		logic [VALUE_W-1:0] rest;
		int n;
		char_item_t item;
		n = 0;
		rest = num;
		do begin
			if (n < DIGITS_DEPTH) begin
				digits[n] = DIGIT_W'(rest % RADIX);
				n++;
			end
			rest = rest / RADIX;
		end while (rest != 0);
		for (int i = n - 1; i >= 0; i--) begin
			item.digit_char = char_t'(ASCII_ZERO + CHAR_W'(digits[i]));
			item.last = (i == 0);
			expected_chars.push_back(item);
		end
	endfunction

	// random value with an evenly drawn digit count, or any 32-bit pattern
	function automatic logic [VALUE_W-1:0] random_value();
		int n;
		logic [VALUE_W-1:0] lo;
		logic [VALUE_W-1:0] hi;
		n = $urandom_range(11, 1);
		if (n == 11)
			return $urandom();
		lo = 1;
		repeat (n - 1) lo = lo * RADIX;
		hi = (n == 10) ? 32'hFFFF_FFFF : lo * RADIX - 1;
		if (n == 1)
			lo = 0;
		return $urandom_range(hi, lo);
	endfunction

	// offer one value after a random gap and record its digits once it is taken
	task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
		int gap;
		char_item_t item;
		gap = number_gaps ? $urandom_range(7, 0) : 0;
		@(negedge clk);
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do @(posedge clk); while (!number_ch.ready);
		if (text.len() == 0)
			predict_text(v);
		else begin
			for (int i = 0; i < text.len(); i++) begin
				item.digit_char = CHAR_W'(text[i]);
				item.last = (i == text.len() - 1);
				expected_chars.push_back(item);
			end
		end
	endtask

	// hold the input back until every digit has come out
	task automatic drain_text();
		@(negedge clk);
		number_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) @(negedge clk);
	endtask

	// output side: ready follows a per-item stall drawn on each accepted item
	initial begin
		text_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (text_hold > 0) begin
				text_ch.ready <= 1'b0;
				text_hold--;
			end else
				text_ch.ready <= 1'b1;
		end
	end

	// check each accepted digit against the oldest expectation
	always @(posedge clk) begin : check_text
		char_item_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			chars_seen++;
			if (chars_seen % 40 == 0)
				text_stalls = ($urandom_range(2, 0) != 0);
			text_hold = text_stalls ? $urandom_range(7, 0) : 0;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected digit char %0d last %0b",
					$time, text_ch.digit_char, text_ch.last);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (want.digit_char !== text_ch.digit_char) begin
					$display("%0t: digit char expected %0d actual %0d",
						$time, want.digit_char, text_ch.digit_char);
					errors++;
				end
				if (want.last !== text_ch.last) begin
					$display("%0t: last expected %0b actual %0b",
						$time, want.last, text_ch.last);
					errors++;
				end
			end
		end
	end

	// watchdog: too long without any item moving on either side
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// reset, directed table, random values, then wait out the tail
	initial begin
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++)
			send_value(value_rows[r].value, value_rows[r].text);
		drain_text();

		for (int k = 0; k < RANDOM_VALUES; k++) begin
			if (k % 30 == 0)
				number_gaps = ($urandom_range(2, 0) != 0);
			if (k == DRAIN_AT)
				drain_text();
			send_value(random_value(), "");
		end
		@(negedge clk);
		number_ch.valid <= 1'b0;

		while (expected_chars.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// File: unsigned_to_decimal_text.f
+incdir+hdl
hdl/udt_pkg.sv
hdl/udt_value_if.sv
hdl/udt_char_if.sv
hdl/udt_ram.sv
hdl/udt_front.sv
hdl/udt_job_queue.sv
hdl/udt_back.sv
hdl/unsigned_to_decimal_text.sv
dv/tb_unsigned_to_decimal_text.sv
